[design/a2f_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and the CORDIC step-angle table for the atan2 unit.
package a2f_pkg;

   localparam int SAMPLE_WIDTH    = 12;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int ANGLE_WIDTH     = 16;

   localparam int WORK_WIDTH   = 64;
   localparam int WORK_FRAC    = 62;
   localparam int CORDIC_STEPS = 62;
   // leading one of the larger operand is placed at this bit
   localparam int NORM_TOP     = 60;

   localparam int MSB_WIDTH   = (SAMPLE_WIDTH > 1) ? $clog2(SAMPLE_WIDTH) : 1;
   localparam int SHIFT_WIDTH = $clog2(NORM_TOP + 1);
   localparam int ROUND_SHIFT = WORK_FRAC - ANGLE_FRAC_BITS;

   typedef logic [WORK_WIDTH-1:0]   work_type;
   typedef logic [SAMPLE_WIDTH-1:0] mag_type;
   typedef logic [ANGLE_WIDTH-1:0]  angle_type;
   typedef work_type                step_table_type [CORDIC_STEPS];

   localparam work_type PI_W         = 64'hC90FDAA22168C235;
   localparam work_type HALF_PI_W    = 64'h6487ED5110B4611A;
   localparam work_type QUARTER_PI_W = 64'h3243F6A8885A308D;
   localparam work_type ROUND_HALF   = work_type'(1) << (ROUND_SHIFT - 1);

   // per-request side information that rides along the pipeline
   typedef struct packed {
      logic both_zero;
      logic a_zero;
      logic swapped;
      logic dneg;
      logic nneg;
   } flags_type;

   // restoring division; only used to build the constant table below
   function automatic work_type quot_of(work_type num, work_type den);
      work_type q;
      work_type rem;
      q   = '0;
      rem = '0;
      for (int b = WORK_WIDTH - 1; b >= 0; b--) begin
         rem = {rem[WORK_WIDTH-2:0], num[b]};
         if (rem >= den) begin
            rem  = rem - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-i) at WORK_FRAC fraction bits, from the odd power series
   function automatic step_table_type build_step_angles();
      step_table_type tbl;
      work_type       sum;
      work_type       term;
      int             e;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         sum = '0;
         for (int k = 0; k < 32; k++) begin
            e = (2 * k + 1) * i;
            if (i != 0 && e <= WORK_FRAC) begin
               term = quot_of(work_type'(1) << (WORK_FRAC - e), work_type'(2 * k + 1));
               if (k[0]) begin
                  sum = sum - term;
               end else begin
                  sum = sum + term;
               end
            end
         end
         tbl[i] = (i == 0) ? QUARTER_PI_W : sum;
      end
      return tbl;
   endfunction

   localparam step_table_type STEP_ANGLE = build_step_angles();

endpackage

[design/atan2_fixed_point.sv]
`timescale 1ns / 1ps
// Pipeline: 2 fold, 62 CORDIC and 3 finish stages, then 1 output register to rsp_valid.
// One request per cycle while req_ready is high; every stage advances together on one enable.
// The two-entry output buffer lets the pipeline keep moving while one result waits.
// Synchronous active-high reset clears all valid bits and the output buffer count;
// datapath registers are not reset.
// Top level of the four-quadrant fixed-point arctangent unit.
module atan2_fixed_point
   import a2f_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_numerator_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] req_denominator_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [ANGLE_WIDTH-1:0]  rsp_angle
);

   logic      en;
   logic      fold_valid, cordic_valid, fin_valid;
   work_type  fold_x, fold_ym, cordic_z;
   flags_type fold_flags, cordic_flags;
   angle_type fin_angle;

   logic       push, pop;
   logic [1:0] count_ff, count_in;
   angle_type  head_ff, head_in, tail_ff, tail_in;

   // advance whenever the output buffer can take one more result
   assign en        = (count_ff != 2'd2) || rsp_ready;
   assign req_ready = en;

   a2f_fold u_fold (
      .clock              (clock),
      .reset              (reset),
      .en                 (en),
      .in_valid           (req_valid),
      .numerator_sample   (req_numerator_sample),
      .denominator_sample (req_denominator_sample),
      .out_valid          (fold_valid),
      .out_x              (fold_x),
      .out_ym             (fold_ym),
      .out_flags          (fold_flags)
   );

   a2f_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fold_valid),
      .in_x      (fold_x),
      .in_ym     (fold_ym),
      .in_flags  (fold_flags),
      .out_valid (cordic_valid),
      .out_z     (cordic_z),
      .out_flags (cordic_flags)
   );

   a2f_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cordic_valid),
      .in_z      (cordic_z),
      .in_flags  (cordic_flags),
      .out_valid (fin_valid),
      .out_angle (fin_angle)
   );

   assign push = en && fin_valid;
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      priority if (push && pop) begin
         if (count_ff == 2'd1) begin
            head_in = fin_angle;
         end else begin
            head_in = tail_ff;
            tail_in = fin_angle;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_in = fin_angle;
         end else begin
            tail_in = fin_angle;
         end
         count_in = count_ff + 2'd1;
      end else if (pop) begin
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_angle = head_ff;

endmodule

[design/a2f_fold.sv]
`timescale 1ns / 1ps
// Front end: sample magnitudes, octant fold and normalization (two stages).
module a2f_fold
   import a2f_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [SAMPLE_WIDTH-1:0] numerator_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] denominator_sample,
   output logic                           out_valid,
   output work_type                       out_x,
   output work_type                       out_ym,
   output flags_type                      out_flags
);

   mag_type   nraw, draw, nmag, dmag;
   logic      nneg, dneg, swapped;
   mag_type   a_in, b_in;
   flags_type flags1_in;

   logic      valid1_ff;
   mag_type   a1_ff, b1_ff;
   flags_type flags1_ff;

   logic [MSB_WIDTH-1:0]   msb;
   logic [SHIFT_WIDTH-1:0] shift;
   work_type               x_in, ym_in;

   logic      valid2_ff;
   work_type  x2_ff, ym2_ff;
   flags_type flags2_ff;

   // stage 1: magnitudes (most negative sample maps to 2^(w-1) exactly)
   always_comb begin
      nraw    = mag_type'(numerator_sample);
      draw    = mag_type'(denominator_sample);
      nneg    = nraw[SAMPLE_WIDTH-1];
      dneg    = draw[SAMPLE_WIDTH-1];
      nmag    = nneg ? (~nraw + mag_type'(1)) : nraw;
      dmag    = dneg ? (~draw + mag_type'(1)) : draw;
      swapped = nmag > dmag;
      a_in    = swapped ? dmag : nmag;
      b_in    = swapped ? nmag : dmag;
      flags1_in.both_zero = (nmag == '0) && (dmag == '0);
      flags1_in.a_zero    = (a_in == '0);
      flags1_in.swapped   = swapped;
      flags1_in.dneg      = dneg;
      flags1_in.nneg      = nneg;
   end

   // stage 2: put the leading one of b at NORM_TOP
   always_comb begin
      msb = '0;
      for (int j = 0; j < SAMPLE_WIDTH; j++) begin
         if (b1_ff[j]) begin
            msb = MSB_WIDTH'(j);
         end
      end
      shift = SHIFT_WIDTH'(NORM_TOP) - SHIFT_WIDTH'(msb);
      x_in  = work_type'(b1_ff) << shift;
      ym_in = work_type'(a1_ff) << shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff     <= a_in;
         b1_ff     <= b_in;
         flags1_ff <= flags1_in;
         x2_ff     <= x_in;
         ym2_ff    <= ym_in;
         flags2_ff <= flags1_ff;
      end
   end

   assign out_valid = valid2_ff;
   assign out_x     = x2_ff;
   assign out_ym    = ym2_ff;
   assign out_flags = flags2_ff;

endmodule

[design/a2f_cordic.sv]
`timescale 1ns / 1ps
// Vectoring CORDIC, one registered stage per step, magnitude/sign form of y.
module a2f_cordic
   import a2f_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  work_type  in_x,
   input  work_type  in_ym,
   input  flags_type in_flags,
   output logic      out_valid,
   output work_type  out_z,
   output flags_type out_flags
);

   logic              valid_src [CORDIC_STEPS];
   work_type          x_src     [CORDIC_STEPS];
   work_type          ym_src    [CORDIC_STEPS];
   work_type          z_src     [CORDIC_STEPS];
   logic              yneg_src  [CORDIC_STEPS];
   flags_type         flags_src [CORDIC_STEPS];

   work_type          xs        [CORDIC_STEPS];
   work_type          ys        [CORDIC_STEPS];
   logic [WORK_WIDTH:0] diff    [CORDIC_STEPS];

   work_type          x_in      [CORDIC_STEPS];
   work_type          ym_in     [CORDIC_STEPS];
   work_type          z_in      [CORDIC_STEPS];
   logic              yneg_in   [CORDIC_STEPS];

   logic              valid_ff  [CORDIC_STEPS];
   work_type          x_ff      [CORDIC_STEPS];
   work_type          ym_ff     [CORDIC_STEPS];
   work_type          z_ff      [CORDIC_STEPS];
   logic              yneg_ff   [CORDIC_STEPS];
   flags_type         flags_ff  [CORDIC_STEPS];

   always_comb begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (i == 0) begin
            valid_src[i] = in_valid;
            x_src[i]     = in_x;
            ym_src[i]    = in_ym;
            z_src[i]     = '0;
            yneg_src[i]  = 1'b0;
            flags_src[i] = in_flags;
         end else begin
            valid_src[i] = valid_ff[i-1];
            x_src[i]     = x_ff[i-1];
            ym_src[i]    = ym_ff[i-1];
            z_src[i]     = z_ff[i-1];
            yneg_src[i]  = yneg_ff[i-1];
            flags_src[i] = flags_ff[i-1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs[i]   = x_src[i] >> i;
         ys[i]   = ym_src[i] >> i;
         diff[i] = {1'b0, ym_src[i]} - {1'b0, xs[i]};
         x_in[i] = x_src[i] + ys[i];
         if (!yneg_src[i]) begin
            z_in[i] = z_src[i] + STEP_ANGLE[i];
            if (!diff[i][WORK_WIDTH]) begin
               ym_in[i]   = diff[i][WORK_WIDTH-1:0];
               yneg_in[i] = 1'b0;
            end else begin
               ym_in[i]   = xs[i] - ym_src[i];
               yneg_in[i] = 1'b1;
            end
         end else begin
            z_in[i] = z_src[i] - STEP_ANGLE[i];
            // y crosses zero (or lands on it) when |y| <= xs
            if (!diff[i][WORK_WIDTH] && (ym_src[i] != xs[i])) begin
               ym_in[i]   = diff[i][WORK_WIDTH-1:0];
               yneg_in[i] = 1'b1;
            end else begin
               ym_in[i]   = xs[i] - ym_src[i];
               yneg_in[i] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            valid_ff[i] <= valid_src[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            x_ff[i]     <= x_in[i];
            ym_ff[i]    <= ym_in[i];
            z_ff[i]     <= z_in[i];
            yneg_ff[i]  <= yneg_in[i];
            flags_ff[i] <= flags_src[i];
         end
      end
   end

   assign out_valid = valid_ff[CORDIC_STEPS-1];
   assign out_z     = z_ff[CORDIC_STEPS-1];
   assign out_flags = flags_ff[CORDIC_STEPS-1];

endmodule

[design/a2f_finish.sv]
`timescale 1ns / 1ps
// Back end: clamp, octant and quadrant restore, rounding and sign (three stages).
module a2f_finish
   import a2f_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  work_type  in_z,
   input  flags_type in_flags,
   output logic      out_valid,
   output angle_type out_angle
);

   work_type            t1_in, t2_in;
   logic [WORK_WIDTH:0] sum;
   logic [WORK_WIDTH:0] shifted;
   angle_type           r;
   angle_type           angle_in;

   logic      valid1_ff, valid2_ff, valid3_ff;
   work_type  t1_ff, t2_ff;
   flags_type flags1_ff, flags2_ff;
   angle_type angle_ff;

   // stage 1: clamp to [0, pi/4] (zero when a is zero), then fold back across the diagonal
   always_comb begin
      if (in_z[WORK_WIDTH-1]) begin
         t1_in = '0;
      end else if (in_z > QUARTER_PI_W) begin
         t1_in = QUARTER_PI_W;
      end else begin
         t1_in = in_z;
      end
      if (in_flags.a_zero) begin
         t1_in = '0;
      end
      if (in_flags.swapped) begin
         t1_in = HALF_PI_W - t1_in;
      end
   end

   // stage 2: left half plane
   always_comb begin
      t2_in = flags1_ff.dneg ? (PI_W - t1_ff) : t1_ff;
   end

   // stage 3: round half up on the magnitude, then apply the numerator sign; zero for the origin
   always_comb begin
      sum      = {1'b0, t2_ff} + {1'b0, ROUND_HALF};
      shifted  = sum >> ROUND_SHIFT;
      r        = shifted[ANGLE_WIDTH-1:0];
      angle_in = flags2_ff.nneg ? (~r + angle_type'(1)) : r;
      if (flags2_ff.both_zero) begin
         angle_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff     <= t1_in;
         flags1_ff <= in_flags;
         t2_ff     <= t2_in;
         flags2_ff <= flags1_ff;
         angle_ff  <= angle_in;
      end
   end

   assign out_valid = valid3_ff;
   assign out_angle = angle_ff;

endmodule

[tb/tb_atan2_fixed_point.sv]
`timescale 1ns / 1ps
// Self-checking testbench for atan2_fixed_point: queued request driver, checking response monitor.
module tb_atan2_fixed_point;
   import a2f_pkg::*;

   localparam int          RESET_CYCLES = 12;
   localparam int          IDLE_PCT     = 21;
   localparam int          RANDOM_ITEMS = 950;
   localparam int          STALL_LIMIT  = 2000;
   localparam int          TAIL_CYCLES  = 100;
   localparam int          HOLD_CYCLES  = 250;
   localparam int          HOLD_AT      = 300;
   localparam int          CALM_FROM    = 500;
   localparam int          CALM_TO      = 700;
   localparam int          MAX_REPORTS  = 10;
   localparam int          FIX_FRAC     = 62;
   localparam int          ARC_STEPS    = 62;
   localparam logic [63:0] ARC_PI       = 64'hC90FDAA22168C235;
   localparam logic [63:0] ARC_HALF_PI  = 64'h6487ED5110B4611A;
   localparam logic [63:0] ARC_QUART_PI = 64'h3243F6A8885A308D;
   localparam int          DROP_BITS    = FIX_FRAC - ANGLE_FRAC_BITS;

   typedef struct {
      logic [SAMPLE_WIDTH-1:0] num;
      logic [SAMPLE_WIDTH-1:0] den;
      bit                      drain;   // wait for all outstanding results before offering
   } sample_pair_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [SAMPLE_WIDTH-1:0] req_numerator_sample = '0;
   logic signed [SAMPLE_WIDTH-1:0] req_denominator_sample = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic signed [ANGLE_WIDTH-1:0]  rsp_angle;

   sample_pair_type                pend_q[$];
   logic [ANGLE_WIDTH-1:0]         angle_q[$];
   logic [63:0]                    arc_tab[ARC_STEPS];
   int                             req_count = 0;
   int                             rsp_count = 0;
   int                             fail_count = 0;
   int                             directed_count = 0;
   int                             hold_left = 0;
   bit                             hold_done = 1'b0;
   int                             idle_cycles = 0;
   bit                             calm;

   atan2_fixed_point i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_numerator_sample   (req_numerator_sample),
      .req_denominator_sample (req_denominator_sample),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_angle              (rsp_angle)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   assign calm = (req_count >= CALM_FROM) && (req_count < CALM_TO);

   // atan(2^-i) from the odd power series, FIX_FRAC fraction bits
   function automatic logic [63:0] arc_step(int i);
      logic [63:0] sum;
      logic [63:0] term;
      int          e;
      sum = '0;
      if (i == 0) return ARC_QUART_PI;
      for (int k = 0; k < 64; k++) begin
         e = (2 * k + 1) * i;
         if (e > FIX_FRAC) break;
         term = (64'd1 << (FIX_FRAC - e)) / 64'(2 * k + 1);
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // vectoring CORDIC on 0 < a <= b, sign of y kept apart from its magnitude
   function automatic logic [63:0] octant_arc(logic [63:0] a, logic [63:0] b);
      int          msb;
      logic [63:0] x;
      logic [63:0] ym;
      logic [63:0] xs;
      logic [63:0] ys;
      logic [63:0] z;
      bit          yneg;
      msb = 0;
      while (msb < 63 && (b >> (msb + 1)) != 0) msb++;
      x    = b << (60 - msb);
      ym   = a << (60 - msb);
      z    = '0;
      yneg = 1'b0;
      for (int i = 0; i < ARC_STEPS; i++) begin
         xs = x >> i;
         ys = ym >> i;
         x  = x + ys;
         if (!yneg) begin
            z = z + arc_tab[i];
            if (ym >= xs) begin
               ym = ym - xs;
            end else begin
               ym   = xs - ym;
               yneg = 1'b1;
            end
         end else begin
            z = z - arc_tab[i];
            if (ym > xs) begin
               ym = ym - xs;
            end else begin
               ym   = xs - ym;
               yneg = 1'b0;
            end
         end
      end
      if (z[63]) z = '0;
      if (z > ARC_QUART_PI) z = ARC_QUART_PI;
      return z;
   endfunction

   function automatic logic [ANGLE_WIDTH-1:0] predict_angle(logic [SAMPLE_WIDTH-1:0] num,
                                                            logic [SAMPLE_WIDTH-1:0] den);
      bit          nneg;
      bit          dneg;
      bit          swapped;
      logic [63:0] nmag;
      logic [63:0] dmag;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] t;
      logic [63:0] r;
      nneg = num[SAMPLE_WIDTH-1];
      dneg = den[SAMPLE_WIDTH-1];
      // most negative sample keeps its full magnitude
      nmag = nneg ? (64'd1 << SAMPLE_WIDTH) - 64'(num) : 64'(num);
      dmag = dneg ? (64'd1 << SAMPLE_WIDTH) - 64'(den) : 64'(den);
      if (nmag == 0 && dmag == 0) return '0;
      swapped = nmag > dmag;
      a = swapped ? dmag : nmag;
      b = swapped ? nmag : dmag;
      t = (a == 0) ? 64'd0 : octant_arc(a, b);
      if (swapped) t = ARC_HALF_PI - t;
      if (dneg) t = ARC_PI - t;
      r = (t + (64'd1 << (DROP_BITS - 1))) >> DROP_BITS;
      if (nneg) r = 64'd0 - r;
      return r[ANGLE_WIDTH-1:0];
   endfunction

   task automatic add_pair(int num, int den, bit drain = 1'b0);
      sample_pair_type p;
      p.num   = SAMPLE_WIDTH'(num);
      p.den   = SAMPLE_WIDTH'(den);
      p.drain = drain;
      pend_q.push_back(p);
   endtask

   function automatic int rand_sample();
      return int'($urandom_range(4095)) - 2048;
   endfunction

   // request driver
   always @(posedge clock) begin
      sample_pair_type p;
      bit              taken;
      if (reset) begin
         req_valid              <= 1'b0;
         req_numerator_sample   <= '0;
         req_denominator_sample <= '0;
      end else begin
         taken = req_valid && req_ready;
         if (taken) begin
            angle_q.push_back(predict_angle(req_numerator_sample, req_denominator_sample));
            req_count++;
         end
         if (!req_valid || taken) begin
            if (pend_q.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pend_q[0].drain && angle_q.size() != 0) begin
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
               req_valid <= 1'b0;
            end else begin
               p = pend_q.pop_front();
               req_valid              <= 1'b1;
               req_numerator_sample   <= p.num;
               req_denominator_sample <= p.den;
            end
         end
      end
   end

   // response monitor and output-side backpressure
   always @(posedge clock) begin
      logic [ANGLE_WIDTH-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (angle_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("[%0t] unexpected response: angle %0d", $realtime, rsp_angle);
            end else begin
               want = angle_q.pop_front();
               if (rsp_angle !== want) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("[%0t] angle mismatch on response %0d: expected %0d, got %0d",
                              $realtime, rsp_count, $signed(want), rsp_angle);
               end
            end
         end
         // one long hold-off lets the pipeline fill and stall the request side
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && req_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int mode;
      int m;
      int v;
      for (int i = 0; i < ARC_STEPS; i++) arc_tab[i] = arc_step(i);

      // axes, origin, full-scale corners and near-pi cases
      add_pair(0, 0);
      add_pair(0, 5);
      add_pair(0, -5);
      add_pair(5, 0);
      add_pair(-5, 0);
      add_pair(0, -2048);
      add_pair(-2048, 0);
      add_pair(2047, 0);
      add_pair(2047, 2047);
      add_pair(-2048, -2048);
      add_pair(2047, -2048);
      add_pair(-2048, 2047);
      add_pair(1, 2047);
      add_pair(1, -2048);
      add_pair(-1, -2048);
      add_pair(-1, 2047);
      add_pair(2047, 1);
      add_pair(3, 4);
      add_pair(-3, 4);
      add_pair(3, -4);
      add_pair(-3, -4);
      add_pair(1, 1);
      add_pair(-1, -1);
      add_pair(100, -100);
      add_pair(-2048, -1);
      directed_count = pend_q.size();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         mode = $urandom_range(9);
         case (mode)
            6: add_pair(int'($urandom_range(16)) - 8, int'($urandom_range(16)) - 8);
            7: begin
               if ($urandom_range(1)) add_pair(0, rand_sample());
               else add_pair(rand_sample(), 0);
            end
            8: begin
               m = $urandom_range(2048);
               v = $urandom_range(1) ? -m : m;
               add_pair(v, $urandom_range(1) ? -m : m);
            end
            9: begin
               v = $urandom_range(1) ? -2048 : 2047;
               if ($urandom_range(1)) add_pair(v, rand_sample());
               else add_pair(rand_sample(), v);
            end
            default: add_pair(rand_sample(), rand_sample());
         endcase
         // sender pauses until the pipeline has drained, right after directed and mid-run
         if (n == 0 || n == 600) pend_q[pend_q.size() - 1].drain = 1'b1;
      end
      // first random request carries the drain mark
      pend_q[directed_count].drain = 1'b1;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pend_q.size() != 0 || req_valid) @(posedge clock);
      while (angle_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d requests (%0d directed, rest random over all quadrants and axes)",
               req_count, directed_count);
      $display("checked %0d angles through one long output stall and two drain pauses",
               rsp_count);
      if (fail_count == 0 && angle_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d failures", fail_count);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
